[rtl/tbsm_pkg.sv]
// Shared types and constants for the touch baseline stage machine.
// Stage one-hot encoding, flag bit positions, register indexes, result layout.
// No dependencies.
package tbsm_pkg;

    // Stage numbers as they appear on the result channel
    localparam logic [3:0] CODE_STABLE   = 4'd0;
    localparam logic [3:0] CODE_RESET    = 4'd1;
    localparam logic [3:0] CODE_NOISY    = 4'd2;
    localparam logic [3:0] CODE_FORCED   = 4'd3;
    localparam logic [3:0] CODE_PRE      = 4'd4;
    localparam logic [3:0] CODE_TOUCH    = 4'd5;
    localparam logic [3:0] CODE_RELEASE  = 4'd6;
    localparam logic [3:0] CODE_POST     = 4'd7;
    localparam logic [3:0] CODE_POST_ALT = 4'd8;
    localparam logic [3:0] CODE_DEBOUNCE = 4'd9;

    // Internal stage register, one-hot
    typedef enum logic [9:0] {
        ST_STABLE   = 10'b00_0000_0001,
        ST_RESET    = 10'b00_0000_0010,
        ST_NOISY    = 10'b00_0000_0100,
        ST_FORCED   = 10'b00_0000_1000,
        ST_PRE      = 10'b00_0001_0000,
        ST_TOUCH    = 10'b00_0010_0000,
        ST_RELEASE  = 10'b00_0100_0000,
        ST_POST     = 10'b00_1000_0000,
        ST_POST_ALT = 10'b01_0000_0000,
        ST_DEBOUNCE = 10'b10_0000_0000
    } t_stage;

    // Bit positions inside property_flags
    localparam int FLAG_RESET    = 0;
    localparam int FLAG_NOISY    = 1;
    localparam int FLAG_UNSTABLE = 2;
    localparam int FLAG_DEBOUNCE = 3;
    localparam int FLAG_FORCED   = 4;
    localparam int FLAG_TOUCH    = 5;
    localparam int FLAG_WEAK     = 6;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_INTERVAL = 2'd0;
    localparam logic [1:0] REG_PEAK_THRESHOLD = 2'd1;

    // Settle timeout in ms
    localparam logic [32:0] SETTLE_MS = 33'd408;

    // Result item, packed so that new_stage sits in the lowest bits
    typedef struct packed {
        logic       stage_changed;
        logic [7:0] frames_in_stage;
        logic [3:0] previous_stage;
        logic [3:0] new_stage;
    } t_result;

    function automatic logic [3:0] stage_code(t_stage s);
        logic [3:0] c;
        case (s)
            ST_STABLE:   c = CODE_STABLE;
            ST_RESET:    c = CODE_RESET;
            ST_NOISY:    c = CODE_NOISY;
            ST_FORCED:   c = CODE_FORCED;
            ST_PRE:      c = CODE_PRE;
            ST_TOUCH:    c = CODE_TOUCH;
            ST_RELEASE:  c = CODE_RELEASE;
            ST_POST:     c = CODE_POST;
            ST_POST_ALT: c = CODE_POST_ALT;
            ST_DEBOUNCE: c = CODE_DEBOUNCE;
            default:     c = CODE_STABLE;
        endcase
        return c;
    endfunction

endpackage

[rtl/touch_baseline_stage_machine.sv]
// Touch baseline stage machine: per-frame stage update with input and result registers.
// Depends on tbsm_pkg (stage encoding, flag positions, register indexes).
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  s       | in        | i_s_tvalid/o_s_tready | i_s_tdata: one frame request (40 bits)
//  m       | out       | o_m_tvalid/i_m_tready | o_m_tdata: one stage result (24 bits)
//  cfg     | in        | i_cfg_we              | i_cfg_index, i_cfg_data
//
// Rate: one frame request per cycle sustained while i_m_tready stays high; a result is
// offered once its request has passed the input register, then the result register.
// The whole stage update runs in one pass between the two registers.
// Reset: i_rst_n is synchronous, active low; stage returns to stable, counters
// and the touch latch clear, interval reloads to 1 and threshold to 0.
// Stalls: a result waiting on i_m_tready holds the result register; the input
// register still takes one more request, and o_s_tready drops only when both are full.
module touch_baseline_stage_machine #(
    parameter int ELAPSED_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [6:0] property_flags, [22:7] peak_high, [38:23] peak_low, [39] one_finger
    input  logic [39:0] i_s_tdata,
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] new_stage, [7:4] previous_stage, [15:8] frames_in_stage,
    // [16] stage_changed, [23:17] zero
    output logic [23:0] o_m_tdata,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tbsm_pkg::*;

    // Saturation limit of the elapsed-time counter, held at 33 bits for compares
    localparam logic [32:0] ElapsedMax = (33'd1 << ELAPSED_WIDTH) - 33'd1;

    // Configuration
    logic [15:0] r_interval_cfg;
    logic [14:0] r_peak_thr;

    // Input register
    logic        r_in_valid;
    logic [6:0]  r_flags;
    logic [15:0] r_max_sig;
    logic [15:0] r_min_sig;
    logic        r_single;

    // Result register
    logic        r_out_valid;
    t_result     r_res;

    // Stage state
    t_stage                   r_stage,   n_stage;
    logic [ELAPSED_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [7:0]               r_frames,  n_frames;
    logic                     r_latch,   n_latch;

    logic        advance;
    logic        changed;
    logic [32:0] interval_w;
    logic [32:0] sum_w;
    logic [ELAPSED_WIDTH-1:0] interval_sat;
    logic [ELAPSED_WIDTH-1:0] sum_sat;
    logic        timed_out;
    logic        touch;
    logic        quiet;
    logic signed [16:0] thr_s;
    logic signed [16:0] max_s;
    logic signed [16:0] min_s;

    // Move the input register into the result register when the result slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_res};

    // Interval of 0 counts as 1; clip it and the running sum to the elapsed width
    assign interval_w   = (r_interval_cfg == 16'd0) ? 33'd1 : {17'd0, r_interval_cfg};
    assign interval_sat = (interval_w > ElapsedMax) ? ElapsedMax[ELAPSED_WIDTH-1:0]
                                                    : interval_w[ELAPSED_WIDTH-1:0];
    assign sum_w        = {{(33-ELAPSED_WIDTH){1'b0}}, r_elapsed} + interval_w;
    assign sum_sat      = (sum_w > ElapsedMax) ? ElapsedMax[ELAPSED_WIDTH-1:0]
                                               : sum_w[ELAPSED_WIDTH-1:0];
    assign timed_out    = {{(33-ELAPSED_WIDTH){1'b0}}, sum_sat} >= SETTLE_MS;

    // Quiet post-touch frame: signal inside (-thr, thr)
    assign thr_s = $signed({2'b00, r_peak_thr});
    assign max_s = $signed({r_max_sig[15], r_max_sig});
    assign min_s = $signed({r_min_sig[15], r_min_sig});
    assign quiet = (max_s < thr_s) && (min_s > -thr_s);

    assign touch = r_flags[FLAG_TOUCH];

    always_comb begin
        n_stage   = r_stage;
        n_elapsed = r_elapsed;
        n_latch   = r_latch;
        // Override flags in priority order; elapsed time holds under an override unless the stage changes
        if (r_flags[FLAG_RESET]) begin
            n_stage = ST_RESET;
        end else if (r_flags[FLAG_NOISY]) begin
            n_stage = ST_NOISY;
        end else if (r_flags[FLAG_UNSTABLE]) begin
            n_stage = ST_FORCED;
        end else if (r_flags[FLAG_DEBOUNCE]) begin
            n_stage = ST_DEBOUNCE;
        end else if (r_flags[FLAG_FORCED]) begin
            n_stage = ST_FORCED;
        end else begin
            n_elapsed = sum_sat;
            case (r_stage)
                ST_STABLE: begin
                    if (touch) begin
                        n_stage = ST_TOUCH;
                    end else if (r_flags[FLAG_WEAK]) begin
                        n_stage = ST_PRE;
                    end
                end
                ST_RESET, ST_NOISY, ST_FORCED: begin
                    n_stage = ST_STABLE;
                end
                // post-alt is never entered but settles like pre
                ST_PRE, ST_POST_ALT, ST_DEBOUNCE: begin
                    if (touch) begin
                        n_stage = ST_TOUCH;
                    end else if (timed_out) begin
                        n_stage = ST_STABLE;
                    end
                end
                ST_TOUCH: begin
                    // decide release with the old latch, then reload it
                    if (!touch) begin
                        n_stage = r_latch ? ST_PRE : ST_RELEASE;
                    end
                    n_latch = r_single;
                end
                ST_RELEASE: begin
                    if (touch) begin
                        n_stage = ST_TOUCH;
                    end else if (timed_out) begin
                        n_stage = ST_POST;
                    end
                end
                ST_POST: begin
                    if (touch) begin
                        n_stage = ST_TOUCH;
                    end else if (timed_out || quiet) begin
                        n_stage = ST_STABLE;
                    end
                end
                default: begin
                    n_stage = ST_STABLE;
                end
            endcase
        end

        changed = (n_stage != r_stage);
        if (changed) begin
            n_frames  = 8'd1;
            n_elapsed = interval_sat;
        end else if (r_frames != 8'hFF) begin
            n_frames = r_frames + 8'd1;
        end else begin
            n_frames = r_frames;
        end
    end

    // Configuration registers; indexes beyond the list drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval_cfg <= 16'd1;
            r_peak_thr     <= 15'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_FRAME_INTERVAL) begin
                r_interval_cfg <= i_cfg_data;
            end else if (i_cfg_index == REG_PEAK_THRESHOLD) begin
                r_peak_thr <= i_cfg_data[14:0];
            end
        end
    end

    // Valid flags and stage state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_stage     <= ST_STABLE;
            r_elapsed   <= '0;
            r_frames    <= 8'd0;
            r_latch     <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_stage     <= n_stage;
                r_elapsed   <= n_elapsed;
                r_frames    <= n_frames;
                r_latch     <= n_latch;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_flags   <= i_s_tdata[6:0];
            r_max_sig <= i_s_tdata[22:7];
            r_min_sig <= i_s_tdata[38:23];
            r_single  <= i_s_tdata[39];
        end
        if (advance) begin
            r_res.new_stage       <= stage_code(n_stage);
            r_res.previous_stage  <= stage_code(r_stage);
            r_res.frames_in_stage <= n_frames;
            r_res.stage_changed   <= changed;
        end
    end

    // Stage register keeps exactly one bit set
    a_stage_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_stage))
        else $error("stage register lost its one-hot encoding");

    // The stored stage matches the last result produced
    a_stage_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (stage_code(r_stage) == r_res.new_stage))
        else $error("stage state and result new_stage disagree");

    // A stage change always restarts the frame count
    a_change_reloads_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.stage_changed) |-> (r_res.frames_in_stage == 8'd1))
        else $error("stage change without frame count reload");

    // Frame count never reads zero on a delivered result
    a_frames_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.frames_in_stage != 8'd0))
        else $error("result with zero frames in stage");

    // Back-pressure only when both registers hold a request
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled while a register is free");

endmodule
